@@ rtl/core/rcg_pkg.sv @@
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared widths, codes, configuration layout and squared-distance helpers
// for the roundabout collision gate.
// ----------------------------------------------------------------------------
package rcg_pkg;

    // Field widths
    localparam int POS_W      = 24;
    localparam int DIST_W     = 23;
    localparam int CMD_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int DSQ_W      = 2 * POS_W + 2;
    localparam int NUM_OTHERS = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_OWN_POSE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OTHER_A    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_OTHER_B    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DRIVE_CMD  = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_PRIORITY    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAFETY_DISTANCE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_DISTANCE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ZONE_CENTER_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ZONE_CENTER_Y    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ZONE_RADIUS      = 3'd5;

    typedef struct packed {
        logic                     high_priority;
        logic [DIST_W-1:0]        safety_distance;
        logic [DIST_W-1:0]        release_distance;
        logic signed [POS_W-1:0]  zone_center_x;
        logic signed [POS_W-1:0]  zone_center_y;
        logic [DIST_W-1:0]        zone_radius;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        high_priority:    1'b1,
        safety_distance:  23'd39322,
        release_distance: 23'd78643,
        zone_center_x:    24'sd37618,
        zone_center_y:    -24'sd19071,
        zone_radius:      23'd124518
    };

    // Conflict flags from the pair check
    typedef struct packed {
        logic safety_hit;
        logic release_hit;
    } conflict_t;

    // Squared Euclidean distance between two Q8.16 points
    function automatic logic [DSQ_W-1:0] dist_sq(
        input logic signed [POS_W-1:0] ax,
        input logic signed [POS_W-1:0] ay,
        input logic signed [POS_W-1:0] bx,
        input logic signed [POS_W-1:0] by
    );
        logic signed [POS_W:0]   dx;
        logic signed [POS_W:0]   dy;
        logic signed [DSQ_W-1:0] sx;
        logic signed [DSQ_W-1:0] sy;
        dx = $signed({ax[POS_W-1], ax} - {bx[POS_W-1], bx});
        dy = $signed({ay[POS_W-1], ay} - {by[POS_W-1], by});
        sx = dx * dx;
        sy = dy * dy;
        return $unsigned(sx) + $unsigned(sy);
    endfunction

    // Square of an unsigned distance, widened to the squared-distance width
    function automatic logic [DSQ_W-1:0] dist_sq_thr(input logic [DIST_W-1:0] d);
        logic [2*DIST_W-1:0] p;
        p = d * d;
        return DSQ_W'(p);
    endfunction

endpackage

@@ rtl/core/rcg_conflict.sv @@
// ----------------------------------------------------------------------------
// rcg_conflict
// Zone membership and pair proximity check of the own vehicle against the
// known other vehicles, at the safety and release thresholds.
// ----------------------------------------------------------------------------
module rcg_conflict (
    input  rcg_pkg::cfg_t                   cfg,
    input  logic                            own_known,
    input  logic signed [rcg_pkg::POS_W-1:0] own_x,
    input  logic signed [rcg_pkg::POS_W-1:0] own_y,
    input  logic [rcg_pkg::NUM_OTHERS-1:0]  other_known,
    input  logic signed [rcg_pkg::POS_W-1:0] other_x [rcg_pkg::NUM_OTHERS],
    input  logic signed [rcg_pkg::POS_W-1:0] other_y [rcg_pkg::NUM_OTHERS],
    output rcg_pkg::conflict_t              hits
);

    logic [rcg_pkg::DSQ_W-1:0]      radius_sq;
    logic [rcg_pkg::DSQ_W-1:0]      safety_sq;
    logic [rcg_pkg::DSQ_W-1:0]      release_sq;
    logic                           own_in;
    logic [rcg_pkg::NUM_OTHERS-1:0] other_in;
    logic [rcg_pkg::NUM_OTHERS-1:0] pair_safety;
    logic [rcg_pkg::NUM_OTHERS-1:0] pair_release;
    logic [rcg_pkg::DSQ_W-1:0]      pair_dsq [rcg_pkg::NUM_OTHERS];

    // Square the thresholds
    assign radius_sq  = rcg_pkg::dist_sq_thr(cfg.zone_radius);
    assign safety_sq  = rcg_pkg::dist_sq_thr(cfg.safety_distance);
    assign release_sq = rcg_pkg::dist_sq_thr(cfg.release_distance);

    // Check the own vehicle against the zone
    assign own_in = own_known &&
        (rcg_pkg::dist_sq(own_x, own_y, cfg.zone_center_x, cfg.zone_center_y)
         <= radius_sq);

    // Check each other vehicle, in parallel
    always_comb
    begin
        for (int i = 0; i < rcg_pkg::NUM_OTHERS; i++)
        begin
            other_in[i] = other_known[i] &&
                (rcg_pkg::dist_sq(other_x[i], other_y[i],
                                  cfg.zone_center_x, cfg.zone_center_y) <= radius_sq);
            pair_dsq[i]     = rcg_pkg::dist_sq(own_x, own_y, other_x[i], other_y[i]);
            pair_safety[i]  = own_in && other_in[i] && (pair_dsq[i] < safety_sq);
            pair_release[i] = own_in && other_in[i] && (pair_dsq[i] < release_sq);
        end
    end

    assign hits.safety_hit  = |pair_safety;
    assign hits.release_hit = |pair_release;

endmodule

@@ rtl/core/roundabout_collision_gate_unit.sv @@
// ----------------------------------------------------------------------------
// roundabout_collision_gate_unit
// A drive command passes through the input register, then the result register.
// Throughput: one transaction per cycle unless a command waits for the result slot;
// the pair check is combinational from the stored positions to the result register.
// Reset: configuration to defaults, all positions unknown, blocking clear.
// ----------------------------------------------------------------------------
module roundabout_collision_gate_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rcg_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [rcg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rcg_pkg::FUNC_W-1:0]          func,
    input  logic signed [rcg_pkg::POS_W-1:0]    pos_x,
    input  logic signed [rcg_pkg::POS_W-1:0]    pos_y,
    input  logic signed [rcg_pkg::CMD_W-1:0]    lin_x,
    input  logic signed [rcg_pkg::CMD_W-1:0]    lin_y,
    input  logic signed [rcg_pkg::CMD_W-1:0]    lin_z,
    input  logic signed [rcg_pkg::CMD_W-1:0]    ang_x,
    input  logic signed [rcg_pkg::CMD_W-1:0]    ang_y,
    input  logic signed [rcg_pkg::CMD_W-1:0]    ang_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rcg_pkg::CMD_W-1:0]    out_lin_x,
    output logic signed [rcg_pkg::CMD_W-1:0]    out_lin_y,
    output logic signed [rcg_pkg::CMD_W-1:0]    out_lin_z,
    output logic signed [rcg_pkg::CMD_W-1:0]    out_ang_x,
    output logic signed [rcg_pkg::CMD_W-1:0]    out_ang_y,
    output logic signed [rcg_pkg::CMD_W-1:0]    out_ang_z,
    output logic                                blocked
);

    rcg_pkg::cfg_t                      cfg_reg;

    // Input register
    logic                               s1_valid_reg;
    logic [rcg_pkg::FUNC_W-1:0]         s1_func_reg;
    logic signed [rcg_pkg::POS_W-1:0]   s1_pos_x_reg;
    logic signed [rcg_pkg::POS_W-1:0]   s1_pos_y_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   s1_lin_x_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   s1_lin_y_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   s1_lin_z_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   s1_ang_x_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   s1_ang_y_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   s1_ang_z_reg;

    // Vehicle state
    logic signed [rcg_pkg::POS_W-1:0]   own_x_reg;
    logic signed [rcg_pkg::POS_W-1:0]   own_y_reg;
    logic                               own_known_reg;
    logic signed [rcg_pkg::POS_W-1:0]   other_x_reg [rcg_pkg::NUM_OTHERS];
    logic signed [rcg_pkg::POS_W-1:0]   other_y_reg [rcg_pkg::NUM_OTHERS];
    logic [rcg_pkg::NUM_OTHERS-1:0]     other_known_reg;
    logic                               blocking_reg;
    logic                               blocking_next;
    logic                               gate;

    // Result register
    logic                               out_valid_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   out_lin_x_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   out_lin_y_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   out_lin_z_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   out_ang_x_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   out_ang_y_reg;
    logic signed [rcg_pkg::CMD_W-1:0]   out_ang_z_reg;
    logic                               blocked_reg;

    logic                               s1_is_cmd;
    logic                               s1_adv;
    rcg_pkg::conflict_t                 hits;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= rcg_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rcg_pkg::REG_HIGH_PRIORITY:
                    cfg_reg.high_priority <= cfg_wdata[0];
                rcg_pkg::REG_SAFETY_DISTANCE:
                    cfg_reg.safety_distance <= cfg_wdata[rcg_pkg::DIST_W-1:0];
                rcg_pkg::REG_RELEASE_DISTANCE:
                    cfg_reg.release_distance <= cfg_wdata[rcg_pkg::DIST_W-1:0];
                rcg_pkg::REG_ZONE_CENTER_X:
                    cfg_reg.zone_center_x <= $signed(cfg_wdata[rcg_pkg::POS_W-1:0]);
                rcg_pkg::REG_ZONE_CENTER_Y:
                    cfg_reg.zone_center_y <= $signed(cfg_wdata[rcg_pkg::POS_W-1:0]);
                rcg_pkg::REG_ZONE_RADIUS:
                    cfg_reg.zone_radius <= cfg_wdata[rcg_pkg::DIST_W-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Advance control: poses never wait, commands wait for a free result slot
    assign s1_is_cmd = (s1_func_reg == rcg_pkg::FUNC_DRIVE_CMD);
    assign s1_adv    = s1_valid_reg && (!s1_is_cmd || !out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_func_reg  <= func;
            s1_pos_x_reg <= pos_x;
            s1_pos_y_reg <= pos_y;
            s1_lin_x_reg <= lin_x;
            s1_lin_y_reg <= lin_y;
            s1_lin_z_reg <= lin_z;
            s1_ang_x_reg <= ang_x;
            s1_ang_y_reg <= ang_y;
            s1_ang_z_reg <= ang_z;
        end
    end

    // Pair check against stored positions
    rcg_conflict u_conflict (
        .cfg         (cfg_reg),
        .own_known   (own_known_reg),
        .own_x       (own_x_reg),
        .own_y       (own_y_reg),
        .other_known (other_known_reg),
        .other_x     (other_x_reg),
        .other_y     (other_y_reg),
        .hits        (hits)
    );

    // Set blocking on a safety conflict unless high priority, release once clear at release range
    always_comb
    begin
        blocking_next = blocking_reg;
        gate          = 1'b0;
        if (own_known_reg)
        begin
            if (hits.safety_hit && !cfg_reg.high_priority)
            begin
                blocking_next = 1'b1;
            end
            else if (blocking_reg && !hits.release_hit)
            begin
                blocking_next = 1'b0;
            end
            gate = blocking_next;
        end
    end

    // Vehicle state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_x_reg       <= '0;
            own_y_reg       <= '0;
            own_known_reg   <= 1'b0;
            other_x_reg[0]  <= '0;
            other_x_reg[1]  <= '0;
            other_y_reg[0]  <= '0;
            other_y_reg[1]  <= '0;
            other_known_reg <= '0;
            blocking_reg    <= 1'b0;
        end
        else if (s1_adv)
        begin
            unique case (s1_func_reg)
                rcg_pkg::FUNC_OWN_POSE:
                begin
                    own_x_reg     <= s1_pos_x_reg;
                    own_y_reg     <= s1_pos_y_reg;
                    own_known_reg <= 1'b1;
                end
                rcg_pkg::FUNC_OTHER_A:
                begin
                    other_x_reg[0]     <= s1_pos_x_reg;
                    other_y_reg[0]     <= s1_pos_y_reg;
                    other_known_reg[0] <= 1'b1;
                end
                rcg_pkg::FUNC_OTHER_B:
                begin
                    other_x_reg[1]     <= s1_pos_x_reg;
                    other_y_reg[1]     <= s1_pos_y_reg;
                    other_known_reg[1] <= 1'b1;
                end
                default:
                begin
                    blocking_reg <= blocking_next;
                end
            endcase
        end
    end

    // Result register valid: load on a command, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_is_cmd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload: zero linear x and angular z while gated
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_is_cmd)
        begin
            out_lin_x_reg <= gate ? '0 : s1_lin_x_reg;
            out_lin_y_reg <= s1_lin_y_reg;
            out_lin_z_reg <= s1_lin_z_reg;
            out_ang_x_reg <= s1_ang_x_reg;
            out_ang_y_reg <= s1_ang_y_reg;
            out_ang_z_reg <= gate ? '0 : s1_ang_z_reg;
            blocked_reg   <= gate;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_lin_x = out_lin_x_reg;
    assign out_lin_y = out_lin_y_reg;
    assign out_lin_z = out_lin_z_reg;
    assign out_ang_x = out_ang_x_reg;
    assign out_ang_y = out_ang_y_reg;
    assign out_ang_z = out_ang_z_reg;
    assign blocked   = blocked_reg;

endmodule
